// ===== hdl/brl_pkg.sv =====
`timescale 1ns / 1ps
// brl_pkg: shared constants for the line rasterizer.
// No dependencies; imported by the interfaces, the rasterizer unit and the bench.
package brl_pkg;

  localparam int ADDR_BITS   = 32;
  localparam int COLOUR_BITS = 16;

  localparam logic [ADDR_BITS-1:0] BASE_RESET = 32'hC800_0000;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_t;

endpackage

// ===== hdl/brl_in_if.sv =====
`timescale 1ns / 1ps
// brl_in_if: valid/ready channel carrying load and step items.
// Depends on brl_pkg.
interface brl_in_if #(
  parameter int COORD_BITS = 9
);
  import brl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [COORD_BITS-1:0]  start_x;
  logic [COORD_BITS-1:0]  start_y;
  logic [COORD_BITS-1:0]  end_x;
  logic [COORD_BITS-1:0]  end_y;
  logic [COLOUR_BITS-1:0] colour;

  modport source (output valid, action, start_x, start_y, end_x, end_y, colour,
                  input ready);
  modport sink   (input valid, action, start_x, start_y, end_x, end_y, colour,
                  output ready);
endinterface

// ===== hdl/brl_out_if.sv =====
`timescale 1ns / 1ps
// brl_out_if: valid/ready channel carrying emitted pixels.
// Depends on brl_pkg.
interface brl_out_if #(
  parameter int COORD_BITS = 9
);
  import brl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [COORD_BITS-1:0]  pixel_x;
  logic [COORD_BITS-1:0]  pixel_y;
  logic [ADDR_BITS-1:0]   pixel_address;
  logic [COLOUR_BITS-1:0] pixel_colour;
  logic                   last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_colour,
                  last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_colour,
                  last_pixel, output ready);
endinterface

// ===== hdl/brl_cfg_if.sv =====
`timescale 1ns / 1ps
// brl_cfg_if: valid/ready write channel for the frame buffer base register.
// Depends on brl_pkg.
interface brl_cfg_if;
  import brl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] buffer_base;

  modport source (output valid, buffer_base, input ready);
  modport sink   (input valid, buffer_base, output ready);
endinterface

// ===== hdl/brl_line_setup.sv =====
`timescale 1ns / 1ps
// brl_line_setup: combinational line setup (axis swap, endpoint order, spans).
// No package dependency; used by bresenham_line_rasterizer_unit.
module brl_line_setup #(
  parameter int COORD_BITS = 9
) (
  input  logic [COORD_BITS-1:0]        start_x,
  input  logic [COORD_BITS-1:0]        start_y,
  input  logic [COORD_BITS-1:0]        end_x,
  input  logic [COORD_BITS-1:0]        end_y,
  output logic [COORD_BITS-1:0]        major_pos,
  output logic [COORD_BITS-1:0]        major_end,
  output logic [COORD_BITS-1:0]        minor_pos,
  output logic [COORD_BITS-1:0]        major_span,
  output logic [COORD_BITS-1:0]        minor_span,
  output logic                         minor_down,
  output logic                         steep,
  output logic signed [COORD_BITS+1:0] err_init
);

  logic [COORD_BITS-1:0] dx, dy;
  logic [COORD_BITS-1:0] a_maj, a_min, b_maj, b_min;
  logic [COORD_BITS-1:0] lo_min, hi_min;
  logic                  swap;

  always_comb begin
    dx    = (start_x > end_x) ? start_x - end_x : end_x - start_x;
    dy    = (start_y > end_y) ? start_y - end_y : end_y - start_y;
    steep = dy > dx;
    a_maj = steep ? start_y : start_x;
    a_min = steep ? start_x : start_y;
    b_maj = steep ? end_y   : end_x;
    b_min = steep ? end_x   : end_y;
    swap  = a_maj > b_maj;

    major_pos  = swap ? b_maj : a_maj;
    major_end  = swap ? a_maj : b_maj;
    lo_min     = swap ? b_min : a_min;
    hi_min     = swap ? a_min : b_min;
    minor_pos  = lo_min;
    major_span = major_end - major_pos;
    minor_span = (lo_min > hi_min) ? lo_min - hi_min : hi_min - lo_min;
    minor_down = !(lo_min < hi_min);
    err_init   = -$signed({2'b00, major_span >> 1});
  end

endmodule

// ===== hdl/bresenham_line_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// Bresenham line rasterizer: a load item (action 0) sets up a line, each step
// item (action 1) emits the next pixel with its frame-buffer byte address
// base + (y << ROW_SHIFT) + (x << 1). One item is accepted per clock while
// in.ready is high; a step's pixel is registered on acceptance. The output
// register decouples the sides: in.ready is low only while a pixel waits and
// out.ready is low. Steps while idle produce nothing; a load restarts the line.
// Depends on brl_pkg, brl_in_if, brl_out_if, brl_cfg_if, brl_line_setup.
module bresenham_line_rasterizer_unit #(
  parameter int COORD_BITS = 9,
  parameter int ROW_SHIFT  = 10
) (
  input  logic     clk,
  input  logic     rst_n,
  brl_in_if.sink   in_ch,
  brl_out_if.source out_ch,
  brl_cfg_if.sink  cfg_ch
);
  import brl_pkg::*;

  localparam int ERR_BITS = COORD_BITS + 2;

  // line state
  logic [COORD_BITS-1:0]      major_pos_r, major_end_r, minor_pos_r;
  logic [COORD_BITS-1:0]      major_span_r, minor_span_r;
  logic signed [ERR_BITS-1:0] err_r;
  logic                       minor_down_r, steep_r, busy_r;
  logic [COLOUR_BITS-1:0]     colour_r;
  logic [ADDR_BITS-1:0]       base_r;

  // output register
  logic                       out_valid_r;
  logic [COORD_BITS-1:0]      px_r, py_r;
  logic [ADDR_BITS-1:0]       addr_r;
  logic [COLOUR_BITS-1:0]     pcol_r;
  logic                       last_r;

  // setup results
  logic [COORD_BITS-1:0]      su_major_pos, su_major_end, su_minor_pos;
  logic [COORD_BITS-1:0]      su_major_span, su_minor_span;
  logic                       su_minor_down, su_steep;
  logic signed [ERR_BITS-1:0] su_err;

  brl_line_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .start_x    (in_ch.start_x),
    .start_y    (in_ch.start_y),
    .end_x      (in_ch.end_x),
    .end_y      (in_ch.end_y),
    .major_pos  (su_major_pos),
    .major_end  (su_major_end),
    .minor_pos  (su_minor_pos),
    .major_span (su_major_span),
    .minor_span (su_minor_span),
    .minor_down (su_minor_down),
    .steep      (su_steep),
    .err_init   (su_err)
  );

  logic                       in_fire, do_load, do_step;
  logic [COORD_BITS-1:0]      px, py;
  logic [ADDR_BITS-1:0]       addr;
  logic                       last;
  logic signed [ERR_BITS-1:0] err_sum, err_nxt;
  logic                       minor_step;
  logic [COORD_BITS-1:0]      minor_nxt;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign do_load      = in_fire && (in_ch.action == ACT_LOAD);
  assign do_step      = in_fire && (in_ch.action == ACT_STEP) && busy_r;

  always_comb begin
    px   = steep_r ? minor_pos_r : major_pos_r;
    py   = steep_r ? major_pos_r : minor_pos_r;
    addr = base_r + (ADDR_BITS'(py) << ROW_SHIFT) + (ADDR_BITS'(px) << 1);
    last = (major_pos_r == major_end_r);

    err_sum    = err_r + $signed({2'b00, minor_span_r});
    minor_step = err_sum > 0;
    err_nxt    = minor_step ? err_sum - $signed({2'b00, major_span_r}) : err_sum;
    if (!minor_step)
      minor_nxt = minor_pos_r;
    else if (minor_down_r)
      minor_nxt = minor_pos_r - 1'b1;
    else
      minor_nxt = minor_pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= BASE_RESET;
    end else begin
      if (cfg_ch.valid)
        base_r <= cfg_ch.buffer_base;

      if (do_load) begin
        busy_r <= 1'b1;
      end else if (do_step && last) begin
        busy_r <= 1'b0;
      end

      if (do_step)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      major_pos_r  <= su_major_pos;
      major_end_r  <= su_major_end;
      minor_pos_r  <= su_minor_pos;
      major_span_r <= su_major_span;
      minor_span_r <= su_minor_span;
      minor_down_r <= su_minor_down;
      steep_r      <= su_steep;
      err_r        <= su_err;
      colour_r     <= in_ch.colour;
    end else if (do_step) begin
      err_r       <= err_nxt;
      minor_pos_r <= minor_nxt;
      if (!last)
        major_pos_r <= major_pos_r + 1'b1;
    end

    if (do_step) begin
      px_r   <= px;
      py_r   <= py;
      addr_r <= addr;
      pcol_r <= colour_r;
      last_r <= last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_x       = px_r;
  assign out_ch.pixel_y       = py_r;
  assign out_ch.pixel_address = addr_r;
  assign out_ch.pixel_colour  = pcol_r;
  assign out_ch.last_pixel    = last_r;

endmodule

// ===== sim/tb_bresenham_line_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// tb_bresenham_line_rasterizer_unit: self-checking bench for the line rasterizer.
// Directed lines, then random load/step items; pixels checked against a line walker.
// Depends on brl_pkg, brl_in_if, brl_out_if, brl_cfg_if, bresenham_line_rasterizer_unit.
module tb_bresenham_line_rasterizer_unit;
  import brl_pkg::*;

  localparam int CB        = 9;
  localparam int ROW_SHIFT = 10;
  localparam int CMAX      = (1 << CB) - 1;
  localparam int ITEM_GOAL = 1350;
  localparam int PHASES    = 5;
  localparam int HOLD_LEN  = 80;
  localparam int IDLE_PCT  = 27;

  typedef struct {
    action_t       act;
    logic [CB-1:0] sx, sy, ex, ey;
    logic [15:0]   col;
  } line_cmd_t;

  typedef struct {
    logic [CB-1:0] x, y;
    logic [31:0]   addr;
    logic [15:0]   col;
    logic          last;
  } pixel_t;

  typedef struct {
    line_cmd_t cmd;
    bit        typed;
    pixel_t    pix;
  } dir_row_t;

  logic clk;
  logic rst_n;

  brl_in_if  #(.COORD_BITS(CB)) in_bus ();
  brl_out_if #(.COORD_BITS(CB)) out_bus ();
  brl_cfg_if                    cfg_bus ();

  bresenham_line_rasterizer_unit #(.COORD_BITS(CB), .ROW_SHIFT(ROW_SHIFT)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  // line walker state
  logic [31:0]   fb_base = BASE_RESET;
  logic [CB-1:0] maj_pos = '0, maj_end = '0, min_pos = '0;
  logic [CB-1:0] maj_span = '0, min_span = '0;
  int            err_acc = 0;
  bit            min_down = 0, steep = 0, line_busy = 0;
  logic [15:0]   line_col = '0;

  pixel_t   expected_pixels[$];
  dir_row_t dir_rows[$];
  pixel_t   blank_pix = '{default: '0};
  int       errors = 0;
  int       items_sent = 0;
  int       hold_requests = 0;
  bit       no_idle = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_bresenham_line_rasterizer_unit: FAIL");
    $finish;
  end

  function automatic logic [CB-1:0] coord_dist(input logic [CB-1:0] a, input logic [CB-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic line_cmd_t mk_cmd(input action_t a, input int sx, input int sy,
                                       input int ex, input int ey, input int col);
    line_cmd_t c;
    c.act = a;
    c.sx  = CB'(sx);
    c.sy  = CB'(sy);
    c.ex  = CB'(ex);
    c.ey  = CB'(ey);
    c.col = 16'(col);
    return c;
  endfunction

  // Advances the walker by one item; returns 1 when a pixel comes out.
  function automatic bit walk_line(input line_cmd_t c, output pixel_t p);
    logic [CB-1:0] a_maj, a_min, b_maj, b_min, t;
    logic [31:0]   ext_x, ext_y;
    p = blank_pix;
    if (c.act == ACT_LOAD) begin
      steep = coord_dist(c.sy, c.ey) > coord_dist(c.sx, c.ex);
      if (steep) begin
        a_maj = c.sy; a_min = c.sx; b_maj = c.ey; b_min = c.ex;
      end else begin
        a_maj = c.sx; a_min = c.sy; b_maj = c.ex; b_min = c.ey;
      end
      if (a_maj > b_maj) begin
        t = a_maj; a_maj = b_maj; b_maj = t;
        t = a_min; a_min = b_min; b_min = t;
      end
      maj_pos   = a_maj;
      maj_end   = b_maj;
      min_pos   = a_min;
      maj_span  = b_maj - a_maj;
      min_span  = coord_dist(a_min, b_min);
      min_down  = !(a_min < b_min);
      err_acc   = -(int'(maj_span) / 2);
      line_col  = c.col;
      line_busy = 1;
      return 0;
    end
    if (!line_busy) return 0;
    p.x    = steep ? min_pos : maj_pos;
    p.y    = steep ? maj_pos : min_pos;
    ext_x  = 32'(p.x);
    ext_y  = 32'(p.y);
    p.addr = fb_base + (ext_y << ROW_SHIFT) + (ext_x << 1);
    p.col  = line_col;
    p.last = (maj_pos == maj_end);
    err_acc += int'(min_span);
    if (err_acc > 0) begin
      min_pos = min_down ? min_pos - 1'b1 : min_pos + 1'b1;
      err_acc -= int'(maj_span);
    end
    if (p.last) line_busy = 0;
    else maj_pos = maj_pos + 1'b1;
    return 1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
    end
  endfunction

  function automatic void add_load(input int sx, input int sy, input int ex, input int ey,
                                   input int col);
    dir_row_t r;
    r.cmd   = mk_cmd(ACT_LOAD, sx, sy, ex, ey, col);
    r.typed = 0;
    r.pix   = blank_pix;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_step();
    dir_row_t r;
    r.cmd   = mk_cmd(ACT_STEP, $urandom_range(CMAX), $urandom_range(CMAX),
                     $urandom_range(CMAX), $urandom_range(CMAX), $urandom_range(16'hFFFF));
    r.typed = 0;
    r.pix   = blank_pix;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_step_exp(input int x, input int y, input logic [31:0] addr,
                                       input int col, input bit last);
    dir_row_t r;
    r.cmd      = mk_cmd(ACT_STEP, 0, 0, 0, 0, 0);
    r.typed    = 1;
    r.pix.x    = CB'(x);
    r.pix.y    = CB'(y);
    r.pix.addr = addr;
    r.pix.col  = 16'(col);
    r.pix.last = last;
    dir_rows.push_back(r);
  endfunction

  // Pixel receiver: checks accepted pixels, drives ready with random stalls.
  initial begin : pixel_sink
    int     hold_left;
    int     holds_served;
    pixel_t want;
    hold_left     = 0;
    holds_served  = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel x=%0d y=%0d addr=%h", $time,
                   out_bus.pixel_x, out_bus.pixel_y, out_bus.pixel_address);
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", 32'(want.x), 32'(out_bus.pixel_x));
          check_field("pixel_y", 32'(want.y), 32'(out_bus.pixel_y));
          check_field("pixel_address", want.addr, out_bus.pixel_address);
          check_field("pixel_colour", 32'(want.col), 32'(out_bus.pixel_colour));
          check_field("last_pixel", 32'(want.last), 32'(out_bus.last_pixel));
        end
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_item(input line_cmd_t c, input bit typed, input pixel_t typed_pix);
    pixel_t p;
    bit     has_pix;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.action  <= c.act;
    in_bus.start_x <= c.sx;
    in_bus.start_y <= c.sy;
    in_bus.end_x   <= c.ex;
    in_bus.end_y   <= c.ey;
    in_bus.colour  <= c.col;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    if (c.act == ACT_LOAD || line_busy) items_sent++;
    has_pix = walk_line(c, p);
    if (typed) expected_pixels.push_back(typed_pix);
    else if (has_pix) expected_pixels.push_back(p);
  endtask

  // Drop valid, wait for outstanding pixels, then let the pipeline settle.
  task automatic finish_phase();
    int guard;
    in_bus.valid <= 1'b0;
    guard = 0;
    while (expected_pixels.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] b);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.buffer_base <= b;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    fb_base = b;
  endtask

  function automatic logic [CB-1:0] near_coord(input logic [CB-1:0] v);
    int n;
    n = int'(v) + int'($urandom_range(32)) - 16;
    return (n < 0) ? '0 : (n > CMAX) ? CB'(CMAX) : CB'(n);
  endfunction

  // Load plus a run of steps: mostly the full line, sometimes cut short or overrun.
  task automatic send_random_line();
    line_cmd_t c;
    int        len;
    int        nsteps;
    int        pick;
    c.act = ACT_LOAD;
    c.sx  = CB'($urandom_range(CMAX));
    c.sy  = CB'($urandom_range(CMAX));
    c.col = 16'($urandom_range(16'hFFFF));
    if ($urandom_range(99) < 3) begin
      c.ex = CB'($urandom_range(CMAX));
      c.ey = CB'($urandom_range(CMAX));
    end else begin
      c.ex = near_coord(c.sx);
      c.ey = near_coord(c.sy);
    end
    len = int'(coord_dist(c.sx, c.ex));
    if (int'(coord_dist(c.sy, c.ey)) > len) len = int'(coord_dist(c.sy, c.ey));
    len++;
    pick = $urandom_range(99);
    if (pick < 80) nsteps = len;
    else if (pick < 90) nsteps = $urandom_range(len - 1);
    else nsteps = len + $urandom_range(1, 3);
    send_item(c, 1'b0, blank_pix);
    repeat (nsteps) begin
      send_item(mk_cmd(ACT_STEP, $urandom_range(CMAX), $urandom_range(CMAX),
                       $urandom_range(CMAX), $urandom_range(CMAX), $urandom_range(16'hFFFF)),
                1'b0, blank_pix);
    end
  endtask

  initial begin : stimulus
    int          goal;
    logic [31:0] base_val;
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.action       = ACT_STEP;
    in_bus.start_x      = '0;
    in_bus.start_y      = '0;
    in_bus.end_x        = '0;
    in_bus.end_y        = '0;
    in_bus.colour       = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.buffer_base = '0;

    add_step();                                   // step while idle: no pixel
    add_load(0, 0, 0, 0, 16'hFFFF);
    add_step_exp(0, 0, 32'hC800_0000, 16'hFFFF, 1'b1);
    add_step();                                   // idle again after last pixel
    add_load(CMAX, CMAX, CMAX, CMAX, 16'h0000);
    add_step_exp(CMAX, CMAX, 32'hC807_FFFE, 16'h0000, 1'b1);
    add_load(CMAX, 0, CMAX - 2, 0, 16'hAAAA);     // reversed horizontal
    repeat (3) add_step();
    add_load(5, CMAX, 5, CMAX - 3, 16'h5555);     // steep, cut short by next load
    repeat (2) add_step();
    add_load(0, CMAX, 3, CMAX - 3, 16'h1234);     // diagonal, minor axis going down
    repeat (4) add_step();
    add_load(500, 3, 2, 0, 16'hF00F);
    repeat (2) add_step();
    add_load(7, 9, 1, 400, 16'h0FF0);
    repeat (2) add_step();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].pix);
    finish_phase();

    goal = items_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: base_val = 32'hFFFF_FFFF;
        1: base_val = 32'h0000_0000;
        4: base_val = BASE_RESET;
        default: base_val = $urandom();
      endcase
      write_base(base_val);
      no_idle = (ph == 2);
      if (ph == 1) begin
        // receiver stalls while a long line keeps being stepped
        send_item(mk_cmd(ACT_LOAD, 3, 450, 203, 420, 16'h07E0), 1'b0, blank_pix);
        hold_requests++;
        repeat (201) send_item(mk_cmd(ACT_STEP, 0, 0, 0, 0, 0), 1'b0, blank_pix);
      end
      goal += ITEM_GOAL / PHASES;
      while (items_sent < goal) begin
        if ($urandom_range(99) < 8) begin
          send_item(mk_cmd(action_t'($urandom_range(1)), $urandom_range(CMAX),
                           $urandom_range(CMAX), $urandom_range(CMAX), $urandom_range(CMAX),
                           $urandom_range(16'hFFFF)), 1'b0, blank_pix);
        end else begin
          send_random_line();
        end
      end
      finish_phase();
    end
    no_idle = 0;
    repeat (10) @(posedge clk);

    if (expected_pixels.size() != 0) begin
      errors++;
      $display("%0t: %0d expected pixels never arrived", $time, expected_pixels.size());
    end
    if (errors == 0) begin
      $display("tb_bresenham_line_rasterizer_unit: PASS");
    end else begin
      $display("tb_bresenham_line_rasterizer_unit: FAIL");
    end
    $finish;
  end

endmodule

// ===== bresenham_line_rasterizer_unit.f =====
hdl/brl_pkg.sv
hdl/brl_in_if.sv
hdl/brl_out_if.sv
hdl/brl_cfg_if.sv
hdl/brl_line_setup.sv
hdl/bresenham_line_rasterizer_unit.sv
sim/tb_bresenham_line_rasterizer_unit.sv
